// File: design/assert_macros.svh
// Assertion helpers used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared constants and types of the suffix trie search core.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned MAX_TEXT   = 32;
  localparam int unsigned TXT_IDX_W  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int unsigned LEN_W      = $clog2(MAX_TEXT + 1);
  localparam int unsigned NODE_COUNT = 1024;
  localparam int unsigned NODE_W     = $clog2(NODE_COUNT);
  localparam int unsigned USED_W     = $clog2(NODE_COUNT + 1);
  localparam int unsigned ALPHABET   = 26;
  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned ROW_W      = ALPHABET * NODE_W;

  localparam logic [7:0] LETTER_BASE = 8'd97;

  typedef enum logic [2:0] {
    KIND_START    = 3'd0,
    KIND_TEXT     = 3'd1,
    KIND_TEXT_END = 3'd2,
    KIND_PAT      = 3'd3,
    KIND_PAT_END  = 3'd4
  } kind_e;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_LONG = 2'd1;
  localparam logic [1:0] ERR_POOL = 2'd2;
  localparam logic [1:0] ERR_CHAR = 2'd3;

  localparam logic ANS_BUILD  = 1'b0;
  localparam logic ANS_SEARCH = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [ROW_W-1:0]  row_t;

endpackage

// File: design/sts_row_ram.sv
// ----------------------------------------------------------------------------
// sts_row_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module sts_row_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/suffix_trie_substring_search_core.sv
// Search: each pattern byte does one child-row read.
// End of text stalls input for the trie build, which walks each suffix letter
// by letter and allocates a node where a child is missing.
// Result appears in the output register the cycle after it is decided.
// Reset: the root row is zeroed in S_INIT; trie empty, text empty, no errors.
// ----------------------------------------------------------------------------
// suffix_trie_substring_search_core
// Builds a suffix trie of a short text in a row-per-node RAM and answers
// substring queries by walking it. A node's row is zeroed when allocated.
// ----------------------------------------------------------------------------
module suffix_trie_substring_search_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic [2:0] s_axis_tuser,   // [2:0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] found, [2:1] error_code, [7:3] zero
  output logic       m_axis_tuser    // [0] answer_kind
);

  import sts_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_PAT, B_NEXT, B_RD, B_EV, B_NEW
  } state_e;

  state_e            state_q, state_d;
  logic [LEN_W-1:0]  text_len_q, text_len_d;
  logic [LETTER_W-1:0] text_store [MAX_TEXT];
  logic [USED_W-1:0] used_q, used_d;
  node_t             node_q, node_d;
  logic [LEN_W-1:0]  start_q, start_d, pos_q, pos_d;
  logic [1:0]        err_q, err_d;
  node_t             snode_q, snode_d;
  logic              failed_q, failed_d, bad_q, bad_d;
  logic [LETTER_W-1:0] pat_let_q, pat_let_d;
  logic              ov_q, ov_d, ou_q, ou_d, of_q, of_d;
  logic [1:0]        oe_q, oe_d;

  logic              ram_en, ram_we;
  node_t             ram_addr;
  row_t              ram_wdata, ram_rdata, row_mod;
  logic              in_acc, is_letter, txt_we;
  logic [LETTER_W-1:0] in_let, cur_let;
  kind_e             kind;
  node_t             child;

  sts_row_ram #(.DEPTH(NODE_COUNT), .WIDTH(ROW_W)) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign kind      = kind_e'(s_axis_tuser);
  assign is_letter = s_axis_tdata inside {[8'd97:8'd122]};
  assign in_let    = LETTER_W'(s_axis_tdata - LETTER_BASE);
  assign cur_let   = text_store[pos_q[TXT_IDX_W-1:0]];

  // results go only into an empty output register
  assign s_axis_tready = (state_q == S_IDLE) &&
      (!ov_q || !(kind == KIND_TEXT_END || kind == KIND_PAT_END));
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // child slot of the row just read
  always_comb begin
    child = ram_rdata[((state_q == S_PAT) ? pat_let_q : cur_let) * NODE_W +: NODE_W];
  end

  // parent row with the new child filled in
  always_comb begin
    row_mod = ram_rdata;
    for (int k = 0; k < ALPHABET; k++) begin
      if (LETTER_W'(k) == cur_let) begin
        row_mod[k*NODE_W +: NODE_W] = used_q[NODE_W-1:0];
      end
    end
  end

  // next-state logic
  always_comb begin
    state_d = state_q;   text_len_d = text_len_q; used_d = used_q;
    node_d = node_q;     start_d = start_q;       pos_d = pos_q;
    err_d = err_q;       snode_d = snode_q;       failed_d = failed_q;
    bad_d = bad_q;       pat_let_d = pat_let_q;
    ov_d = ov_q;         ou_d = ou_q;             of_d = of_q;   oe_d = oe_q;
    ram_en = 1'b0;       ram_we = 1'b0;           ram_addr = '0; ram_wdata = '0;
    txt_we = 1'b0;

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    case (state_q)
      S_INIT: begin
        ram_en = 1'b1; ram_we = 1'b1;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (kind)
            KIND_START: begin
              text_len_d = '0; used_d = USED_W'(1); err_d = ERR_NONE;
              snode_d = '0; failed_d = 1'b0; bad_d = 1'b0;
              ram_en = 1'b1; ram_we = 1'b1;
            end
            KIND_TEXT: begin
              if (!is_letter) begin
                if (err_q == ERR_NONE) err_d = ERR_CHAR;
              end else if (text_len_q >= LEN_W'(MAX_TEXT)) begin
                if (err_q == ERR_NONE) err_d = ERR_LONG;
              end else begin
                txt_we = 1'b1;
                text_len_d = text_len_q + LEN_W'(1);
              end
            end
            KIND_TEXT_END: begin
              used_d = USED_W'(1); start_d = '0;
              ram_en = 1'b1; ram_we = 1'b1;
              state_d = B_NEXT;
            end
            KIND_PAT: begin
              if (!failed_q) begin
                if (!is_letter) begin
                  failed_d = 1'b1; bad_d = 1'b1;
                end else begin
                  pat_let_d = in_let;
                  ram_en = 1'b1; ram_addr = snode_q;
                  state_d = S_PAT;
                end
              end
            end
            KIND_PAT_END: begin
              ov_d = 1'b1; ou_d = ANS_SEARCH; of_d = !failed_q;
              oe_d = bad_q ? ERR_CHAR : err_q;
              snode_d = '0; failed_d = 1'b0; bad_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_PAT: begin
        if (child == '0) failed_d = 1'b1;
        else             snode_d  = child;
        state_d = S_IDLE;
      end
      B_NEXT: begin
        if (start_q == text_len_q) begin
          ov_d = 1'b1; ou_d = ANS_BUILD; of_d = 1'b0; oe_d = err_q;
          snode_d = '0; failed_d = 1'b0; bad_d = 1'b0;
          state_d = S_IDLE;
        end else begin
          node_d = '0; pos_d = start_q;
          state_d = B_RD;
        end
      end
      B_RD: begin
        if (pos_q == text_len_q) begin
          start_d = start_q + LEN_W'(1);
          state_d = B_NEXT;
        end else begin
          ram_en = 1'b1; ram_addr = node_q;
          state_d = B_EV;
        end
      end
      B_EV: begin
        if (child != '0) begin
          node_d = child; pos_d = pos_q + LEN_W'(1);
          state_d = B_RD;
        end else if (used_q >= USED_W'(NODE_COUNT)) begin
          if (err_q == ERR_NONE) err_d = ERR_POOL;
          start_d = start_q + LEN_W'(1);
          state_d = B_NEXT;
        end else begin
          ram_en = 1'b1; ram_we = 1'b1; ram_addr = node_q; ram_wdata = row_mod;
          state_d = B_NEW;
        end
      end
      B_NEW: begin
        // zero the new node's row before anything reads it
        ram_en = 1'b1; ram_we = 1'b1; ram_addr = used_q[NODE_W-1:0];
        node_d = used_q[NODE_W-1:0];
        used_d = used_q + USED_W'(1);
        pos_d = pos_q + LEN_W'(1);
        state_d = B_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // text store, written in arrival order
  always_ff @(posedge clk_i) begin
    if (txt_we) text_store[text_len_q[TXT_IDX_W-1:0]] <= in_let;
  end

  // control and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;  text_len_q <= '0; used_q <= USED_W'(1);
      node_q <= '0;       start_q <= '0;    pos_q <= '0;
      err_q <= ERR_NONE;  snode_q <= '0;    failed_q <= 1'b0;
      bad_q <= 1'b0;      pat_let_q <= '0;
      ov_q <= 1'b0;       ou_q <= 1'b0;     of_q <= 1'b0;  oe_q <= ERR_NONE;
    end else begin
      state_q <= state_d; text_len_q <= text_len_d; used_q <= used_d;
      node_q <= node_d;   start_q <= start_d;       pos_q <= pos_d;
      err_q <= err_d;     snode_q <= snode_d;       failed_q <= failed_d;
      bad_q <= bad_d;     pat_let_q <= pat_let_d;
      ov_q <= ov_d;       ou_q <= ou_d;             of_q <= of_d;  oe_q <= oe_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = ou_q;
  assign m_axis_tdata  = {5'b0, oe_q, of_q};

endmodule

// File: design/sts_checker.sv
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks of the suffix trie search core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic [2:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);

  import sts_pkg::*;

  // a stalled result holds
  `STS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // end of pattern answers in the next cycle
  `STS_ASSERT_NEXT(a_pat_answer, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_PAT_END, m_axis_tvalid && m_axis_tuser == ANS_SEARCH)

  // end of text starts a build that blocks input
  `STS_ASSERT_NEXT(a_build_stall, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_TEXT_END, !s_axis_tready)

  // build result never reports found, padding is zero
  `STS_ASSERT_IMPL(a_build_found, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == ANS_BUILD, m_axis_tdata[0] == 1'b0 && m_axis_tdata[7:3] == 5'd0)

endmodule

bind suffix_trie_substring_search_core sts_checker u_sts_checker (.*);

// File: tb/tb_suffix_trie_substring_search_core.sv
// ----------------------------------------------------------------------------
// tb_suffix_trie_substring_search_core
// Drives texts and patterns into the suffix trie search core, predicts each
// build and search answer with a behavioral trie, and checks every result.
// ----------------------------------------------------------------------------
module tb_suffix_trie_substring_search_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sts_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic       answer_kind;
    logic       found;
    logic [1:0] error_code;
  } answer_t;

  // Expected answers and the behavioral trie that produces them
  class trie_scoreboard;
    logic [LETTER_W-1:0] letters[MAX_TEXT];
    int unsigned         text_len;
    int unsigned         kids[NODE_COUNT][ALPHABET];
    int unsigned         used;
    int unsigned         walk_node;
    bit                  walk_failed;
    bit                  walk_bad;
    logic [1:0]          err_latch;
    answer_t             pending[$];

    function void clear_trie();
      foreach (kids[n, c]) kids[n][c] = 0;
      used = 1;
    endfunction

    function void restart();
      text_len = 0;
      clear_trie();
      walk_node = 0;
      walk_failed = 0;
      walk_bad = 0;
      err_latch = ERR_NONE;
      pending.delete();
    endfunction

    function void latch(logic [1:0] code);
      if (err_latch == ERR_NONE) err_latch = code;
    endfunction

    function bit is_letter(logic [7:0] sym);
      return sym >= LETTER_BASE && sym < LETTER_BASE + ALPHABET;
    endfunction

    function void build_trie();
      int unsigned node;
      int unsigned slot_letter;
      clear_trie();
      for (int s = 0; s < text_len; s++) begin
        node = 0;
        for (int i = s; i < text_len; i++) begin
          slot_letter = letters[i];
          if (kids[node][slot_letter] == 0) begin
            if (used >= NODE_COUNT) begin
              latch(ERR_POOL);
              break;
            end
            kids[node][slot_letter] = used;
            used++;
          end
          node = kids[node][slot_letter];
        end
      end
    endfunction

    // Note one accepted input transfer
    function void note_input(logic [2:0] kind, logic [7:0] sym);
      answer_t a;
      case (kind)
        KIND_START: begin
          text_len = 0;
          clear_trie();
          walk_node = 0; walk_failed = 0; walk_bad = 0;
          err_latch = ERR_NONE;
        end
        KIND_TEXT: begin
          if (!is_letter(sym)) latch(ERR_CHAR);
          else if (text_len >= MAX_TEXT) latch(ERR_LONG);
          else begin
            letters[text_len] = LETTER_W'(sym - LETTER_BASE);
            text_len++;
          end
        end
        KIND_TEXT_END: begin
          build_trie();
          walk_node = 0; walk_failed = 0; walk_bad = 0;
          a.answer_kind = ANS_BUILD; a.found = 1'b0; a.error_code = err_latch;
          pending.push_back(a);
        end
        KIND_PAT: begin
          if (!walk_failed) begin
            if (!is_letter(sym)) begin
              walk_failed = 1; walk_bad = 1;
            end else if (kids[walk_node][sym - LETTER_BASE] == 0) walk_failed = 1;
            else walk_node = kids[walk_node][sym - LETTER_BASE];
          end
        end
        KIND_PAT_END: begin
          a.answer_kind = ANS_SEARCH;
          a.found = !walk_failed;
          a.error_code = walk_bad ? ERR_CHAR : err_latch;
          pending.push_back(a);
          walk_node = 0; walk_failed = 0; walk_bad = 0;
        end
        default: ;
      endcase
    endfunction

    // Compare one output transfer with the oldest expectation; returns mismatch text
    function string check_answer(logic ak, logic [7:0] data);
      answer_t e;
      string msg;
      msg = "";
      if (pending.size() == 0) return $sformatf("unexpected answer kind=%0d data=%h", ak, data);
      e = pending.pop_front();
      if (ak !== e.answer_kind)
        msg = {msg, $sformatf(" answer_kind %0d/%0d", ak, e.answer_kind)};
      if (data[0] !== e.found) msg = {msg, $sformatf(" found %0d/%0d", data[0], e.found)};
      if (data[2:1] !== e.error_code)
        msg = {msg, $sformatf(" error_code %0d/%0d", data[2:1], e.error_code)};
      if (data[7:3] !== 5'd0) msg = {msg, " pad bits nonzero"};
      return msg;
    endfunction
  endclass

  logic       clk_i, rst_ni;
  logic       s_axis_tvalid, s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic [2:0] s_axis_tuser;
  logic       m_axis_tvalid, m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;

  trie_scoreboard sb;
  int unsigned    error_count;
  int unsigned    idle_cycles;
  bit             quiet_phase;
  bit             hold_sink;

  suffix_trie_substring_search_core u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t:%s", $realtime, msg);
    error_count++;
  endtask

  // Monitor both sides and the watchdog
  always @(posedge clk_i) begin
    string m;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        m = sb.check_answer(m_axis_tuser, m_axis_tdata);
        if (m != "") report_mismatch(m);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, a long hold when requested
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_sink = 0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        n = $urandom_range(1, 25);
        m_axis_tready <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Offer one item and wait until it is accepted; valid stays up for the next one
  task automatic send_item(logic [2:0] kind, logic [7:0] sym);
    if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= sym;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter(int span);
    return LETTER_BASE + 8'($urandom_range(0, span - 1));
  endfunction

  // Random byte with occasional non-letters, covering all 8 bits
  function automatic logic [7:0] noisy_byte(int span);
    if ($urandom_range(0, 24) == 0) return 8'($urandom_range(0, 255));
    return rand_letter(span);
  endfunction

  task automatic send_pattern(string p);
    for (int i = 0; i < p.len(); i++) send_item(KIND_PAT, p[i]);
    send_item(KIND_PAT_END, 8'd0);
  endtask

  task automatic directed_part();
    send_pattern("");           // search before any build, empty pattern
    send_pattern("a");          // search before any build, nonempty
    send_item(KIND_START, 8'hff);
    send_item(KIND_TEXT, "a"); send_item(KIND_TEXT, "z"); send_item(KIND_TEXT, "a");
    send_item(KIND_TEXT, 8'd96);   // bad byte just below the letters
    send_item(KIND_TEXT, 8'd123);  // bad byte just above
    send_item(KIND_TEXT_END, 8'd0);
    send_pattern("za");
    send_pattern("zz");
    send_item(KIND_PAT, 8'h00); send_item(KIND_PAT, "a"); send_item(KIND_PAT_END, 8'd0);
    send_item(3'd5, 8'd0); send_item(3'd7, 8'hff);  // unused kinds
    send_pattern("");
  endtask

  // Text too long, then a full-length text of the alphabet in order, wrapping around, that allocates many nodes
  task automatic overflow_part();
    send_item(KIND_START, 8'd0);
    for (int i = 0; i < MAX_TEXT + 2; i++) send_item(KIND_TEXT, rand_letter(26));
    send_item(KIND_TEXT_END, 8'd0);
    send_pattern("q");
    send_item(KIND_START, 8'd0);
    for (int i = 0; i < MAX_TEXT; i++) send_item(KIND_TEXT, LETTER_BASE + 8'(i % 26));
    send_item(KIND_TEXT_END, 8'd0);
    send_pattern("abc");
    send_pattern("zab");
  endtask

  task automatic random_text(int span);
    int len;
    string p;
    int start;
    logic [7:0] txt[$];
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, MAX_TEXT + 3)
                                      : $urandom_range(0, 10);
    if ($urandom_range(0, 5) != 0) send_item(KIND_START, 8'($urandom));
    for (int i = 0; i < len; i++) begin
      txt.push_back(noisy_byte(span));
      send_item(KIND_TEXT, txt[i]);
    end
    if ($urandom_range(0, 19) == 0) send_item(3'($urandom_range(5, 7)), 8'($urandom));
    send_item(KIND_TEXT_END, 8'($urandom));
    repeat ($urandom_range(2, 6)) begin
      if (txt.size() > 0 && $urandom_range(0, 2) != 0) begin
        // substring of the text, possibly perturbed
        start = $urandom_range(0, txt.size() - 1);
        p = "";
        for (int i = start; i < txt.size() && i < start + $urandom_range(1, 6); i++)
          p = {p, string'(txt[i])};
        if ($urandom_range(0, 3) == 0) p = {p, string'(noisy_byte(span))};
      end else begin
        p = "";
        repeat ($urandom_range(0, 4)) p = {p, string'(noisy_byte(span))};
      end
      for (int i = 0; i < p.len(); i++) send_item(KIND_PAT, p[i]);
      if ($urandom_range(0, 15) == 0) send_item(KIND_PAT, 8'd0);
      send_item(KIND_PAT_END, 8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.restart();
    error_count = 0;
    idle_cycles = 0;
    quiet_phase = 0;
    hold_sink = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    s_axis_tuser = KIND_START;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_part();
    overflow_part();
    wait_drained();
    // long receiver hold while the sender keeps offering items
    hold_sink = 1;
    for (int k = 0; k < 4; k++) random_text(3);
    wait_drained();
    for (int k = 0; k < 48; k++) begin
      if (k == 40) quiet_phase = 1;
      random_text(($urandom_range(0, 1) == 0) ? 3 : 26);
    end
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (sb.pending.size() != 0) report_mismatch(" expected answers left over");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
